### hdl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette colour search
// Holds the request codes, the distance width and the record that each cell
// hands to its neighbour along the chain.
// ----------------------------------------------------------------------------
package npc_pkg;

  // Default number of palette entries, one cell each.
  localparam int unsigned PaletteEntriesDefault = 256;

  // Widths fixed by the request fields.
  localparam int unsigned ChanW  = 8;
  localparam int unsigned IndexW = 8;

  // An L1 distance over three 8-bit channels never exceeds 765.
  localparam int unsigned DistW = 10;

  // Running best distance before the first entry; above any real distance,
  // so entry zero always becomes the first candidate.
  localparam logic [DistW-1:0] DIST_START = {DistW{1'b1}};

  // Request codes carried in the mode field.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  // Record handed from one cell to the next whenever the row advances.
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [DistW-1:0]  best_dist;
    logic [IndexW-1:0] best_index;
  } npc_flow_t;

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### hdl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell: one palette slot of the search chain
// Stores one palette entry, captures it from a passing write request and
// updates the running best match of a passing match request.
// ----------------------------------------------------------------------------
module npc_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  npc_pkg::npc_flow_t flow_in,
  output npc_pkg::npc_flow_t flow_out
);
  import npc_pkg::*;

  logic [ChanW-1:0]  entry_red_r;
  logic [ChanW-1:0]  entry_green_r;
  logic [ChanW-1:0]  entry_blue_r;
  logic              valid_r;
  npc_flow_t         flow_r;
  npc_flow_t         flow_nxt;
  logic [DistW-1:0]  entry_dist;
  logic              hit_write;

  assign hit_write = flow_in.valid && (flow_in.mode == MODE_WRITE) &&
                     (flow_in.entry_index == IndexW'(CELL_INDEX));

  always_comb begin
    entry_dist = DistW'(abs_diff(entry_red_r, flow_in.red)) +
                 DistW'(abs_diff(entry_green_r, flow_in.green)) +
                 DistW'(abs_diff(entry_blue_r, flow_in.blue));
    flow_nxt = flow_in;
    // A strict compare keeps the lower index on a tie.
    if (flow_in.mode == MODE_MATCH && entry_dist < flow_in.best_dist) begin
      flow_nxt.best_dist  = entry_dist;
      flow_nxt.best_index = IndexW'(CELL_INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= flow_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flow_r <= flow_nxt;
      if (hit_write) begin
        entry_red_r   <= flow_in.red;
        entry_green_r <= flow_in.green;
        entry_blue_r  <= flow_in.blue;
      end
    end
  end

  always_comb begin
    flow_out       = flow_r;
    flow_out.valid = valid_r;
  end

endmodule

### hdl/nearest_palette_color_l1.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_l1: nearest palette colour by Manhattan distance
// A systolic row of cells, one per palette entry, finds the palette index
// closest to a pixel and stores palette entries as write requests pass.
// ----------------------------------------------------------------------------
//
//   Channel  | Ports                                         | Per request
//   ---------+-----------------------------------------------+----------------
//   input    | in_valid/in_ready, in_mode, in_entry_index,   | one write or
//            | in_red, in_green, in_blue                     | one match
//   result   | out_valid/out_ready, out_best_index           | one per match
//
// One request enters per clock cycle while the row is not held. A match
// passes the first cell, which loads it as it is taken, then each further
// cell and the output register. A write gives no result; it travels the
// same row and is captured by the cell whose index it names, so every match
// sees exactly the writes that were taken before it. Reset clears only the
// valid bits; the palette is undefined until written and has no clearing
// pass. When a result waits and out_ready is low, the whole row holds and
// in_ready falls.
//
module nearest_palette_color_l1 #(
  parameter int unsigned PALETTE_ENTRIES = npc_pkg::PaletteEntriesDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [npc_pkg::IndexW-1:0] in_entry_index,
  input  logic [npc_pkg::ChanW-1:0]  in_red,
  input  logic [npc_pkg::ChanW-1:0]  in_green,
  input  logic [npc_pkg::ChanW-1:0]  in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [npc_pkg::IndexW-1:0] out_best_index
);
  import npc_pkg::*;

  // The chain between cells; element zero is the request at the input.
  npc_flow_t chain [PALETTE_ENTRIES+1];

  logic              advance;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [IndexW-1:0] out_best_index_r;
  npc_flow_t         tail;

  // Every stage moves together; it may move unless a result is waiting
  // unread in the output register.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // A new request starts with no candidate, so the first cell always takes it.
  always_comb begin
    chain[0].valid       = in_valid;
    chain[0].mode        = in_mode;
    chain[0].entry_index = in_entry_index;
    chain[0].red         = in_red;
    chain[0].green       = in_green;
    chain[0].blue        = in_blue;
    chain[0].best_dist   = DIST_START;
    chain[0].best_index  = '0;
  end

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npc_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .flow_in (chain[i]),
      .flow_out(chain[i+1])
    );
  end

  assign tail = chain[PALETTE_ENTRIES];

  // Only match requests leave a result; writes end at the last cell.
  assign out_valid_nxt = tail.valid && (tail.mode == MODE_MATCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_best_index_r <= tail.best_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_best_index_r;

endmodule

### hdl/npc_checker.sv
// ----------------------------------------------------------------------------
// npc_checker: port-level checks for the nearest palette colour search
// Watches the handshakes of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module npc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [npc_pkg::IndexW-1:0] out_best_index
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_index))
    else $error("result changed while stalled");

  // The row stalls, and refuses requests, exactly while a result waits and out_ready is low.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused while output free");

  // Nothing comes out straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind nearest_palette_color_l1 npc_checker u_npc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_best_index(out_best_index)
);

### verif/tb_nearest_palette_color_l1.sv
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_l1: self-checking bench for the palette search
// Loads the palette, sends write and match requests with random gaps on both
// channels, and compares every returned index with a search over a local
// copy of the palette.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_l1;
  import npc_pkg::*;

  localparam int unsigned Entries        = PaletteEntriesDefault;
  localparam int unsigned RandomRequests = 720;
  localparam int unsigned MaxReports     = 30;
  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned LimitCycles    = 1000000;

  // One request as it is planned and later presented on the input channel.
  typedef struct {
    logic              mode;
    logic [IndexW-1:0] entry_index;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } request_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } colour_t;

  // Every input of the block starts at a known value.
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_mode        = MODE_WRITE;
  logic [IndexW-1:0] in_entry_index = '0;
  logic [ChanW-1:0]  in_red         = '0;
  logic [ChanW-1:0]  in_green       = '0;
  logic [ChanW-1:0]  in_blue        = '0;
  logic              out_ready      = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [IndexW-1:0] out_best_index;

  // The plan of requests, and the palette as the plan leaves it, so that
  // match requests can be aimed at colours that really are in the palette.
  request_t    pending_requests[$];
  colour_t     planned_palette[Entries];
  int unsigned requests_planned = 0;

  // The palette as the block holds it once each accepted request has passed,
  // and the indices that the block still owes, oldest first.
  colour_t           shadow_palette[Entries];
  logic [IndexW-1:0] awaited_indices[$];

  int unsigned requests_taken = 0;
  int unsigned writes_taken   = 0;
  int unsigned matches_taken  = 0;
  int unsigned exact_hits     = 0;
  int unsigned results_seen   = 0;
  int unsigned failures       = 0;

  // Idle bookkeeping for the sender and the receiver.
  int unsigned send_hold = 0;
  int unsigned send_calm = 0;
  int unsigned recv_hold = 0;
  int unsigned recv_calm = 0;

  nearest_palette_color_l1 #(
    .PALETTE_ENTRIES(Entries)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_entry_index(in_entry_index),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_best_index(out_best_index)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sum of the absolute channel differences; at most 765, so it always fits
  // the distance width of the package.
  function automatic logic [DistW-1:0] l1_distance(colour_t a, colour_t b);
    int unsigned total;
    total = 0;
    total += (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;
    total += (a.green > b.green) ? a.green - b.green : b.green - a.green;
    total += (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
    return total[DistW-1:0];
  endfunction

  // Walks the palette from entry zero upwards and keeps a candidate only
  // when it is strictly closer, so that a tie leaves the lower index in
  // place. The starting distance lies above any real one, which makes entry
  // zero the first candidate whatever it holds.
  function automatic logic [IndexW-1:0] nearest_entry(colour_t pixel,
                                                      output logic exact);
    logic [DistW-1:0]  best_dist;
    logic [IndexW-1:0] best_slot;
    logic [DistW-1:0]  cand_dist;
    best_dist = DIST_START;
    best_slot = '0;
    for (int i = 0; i < Entries; i++) begin
      cand_dist = l1_distance(shadow_palette[i], pixel);
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_slot = i[IndexW-1:0];
      end
    end
    exact = (best_dist == '0);
    return best_slot;
  endfunction

  // Applies one accepted request to the local palette, or works out the
  // index that the block must return for it. Requests leave the block in the
  // order in which they were taken, so a match sees every earlier write.
  task automatic note_request(logic mode, logic [IndexW-1:0] slot, colour_t c);
    logic exact;
    requests_taken++;
    if (mode == MODE_WRITE) begin
      shadow_palette[slot] = c;
      writes_taken++;
    end else begin
      awaited_indices.push_back(nearest_entry(c, exact));
      matches_taken++;
      if (exact) exact_hits++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------

  function automatic colour_t rgb(int unsigned r, int unsigned g, int unsigned b);
    colour_t c;
    c.red   = r[ChanW-1:0];
    c.green = g[ChanW-1:0];
    c.blue  = b[ChanW-1:0];
    return c;
  endfunction

  function automatic colour_t random_colour();
    return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Each channel at one end of its range or the other.
  function automatic colour_t extreme_colour();
    return rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
               $urandom_range(0, 1) * 255);
  endfunction

  // A colour a few steps away from a given one, kept within the channel range.
  function automatic colour_t near_colour(colour_t c);
    int r;
    int g;
    int b;
    r = int'(c.red)   + $urandom_range(0, 6) - 3;
    g = int'(c.green) + $urandom_range(0, 6) - 3;
    b = int'(c.blue)  + $urandom_range(0, 6) - 3;
    r = (r < 0) ? 0 : (r > 255) ? 255 : r;
    g = (g < 0) ? 0 : (g > 255) ? 255 : g;
    b = (b < 0) ? 0 : (b > 255) ? 255 : b;
    return rgb(r, g, b);
  endfunction

  task automatic plan_write(int unsigned slot, colour_t c);
    request_t rq;
    rq.mode        = MODE_WRITE;
    rq.entry_index = slot[IndexW-1:0];
    rq.red         = c.red;
    rq.green       = c.green;
    rq.blue        = c.blue;
    pending_requests.push_back(rq);
    planned_palette[slot] = c;
  endtask

  // The index field means nothing to a match, so it carries random bits.
  task automatic plan_match(colour_t c);
    request_t rq;
    rq.mode        = MODE_MATCH;
    rq.entry_index = IndexW'($urandom_range(0, 255));
    rq.red         = c.red;
    rq.green       = c.green;
    rq.blue        = c.blue;
    pending_requests.push_back(rq);
  endtask

  // Idle lengths: mostly none or short, now and then long, and from time to
  // time a calm stretch in which no idling happens at all.
  function automatic int unsigned pick_gap(inout int unsigned calm_run);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    if (roll < 3) begin
      calm_run = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the planned requests in order. Valid is raised without
  // regard to ready and held, with the payload unchanged, until the request
  // is taken. In the idle gaps between requests the payload carries random noise.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        note_request(in_mode, in_entry_index, rgb(in_red, in_green, in_blue));
      end
      // A request that was offered and not taken stays where it is.
      if (!(in_valid && !in_ready)) begin
        if (send_hold > 0) begin
          send_hold--;
          in_valid       <= 1'b0;
          in_mode        <= 1'($urandom_range(0, 1));
          in_entry_index <= IndexW'($urandom_range(0, 255));
          in_red         <= ChanW'($urandom_range(0, 255));
          in_green       <= ChanW'($urandom_range(0, 255));
          in_blue        <= ChanW'($urandom_range(0, 255));
        end else if (pending_requests.size() > 0) begin
          rq = pending_requests.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= rq.mode;
          in_entry_index <= rq.entry_index;
          in_red         <= rq.red;
          in_green       <= rq.green;
          in_blue        <= rq.blue;
          send_hold = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes results when out_ready is high, checks each one against
  // the oldest index still owed, and stalls the result channel at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [IndexW-1:0] owed;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_indices.size() == 0) begin
          failures++;
          if (failures <= MaxReports) begin
            $display("%0t: best_index expected none, got %0d", $time, out_best_index);
          end
        end else begin
          owed = awaited_indices.pop_front();
          if (out_best_index !== owed) begin
            failures++;
            if (failures <= MaxReports) begin
              $display("%0t: best_index expected %0d, got %0d", $time, owed,
                       out_best_index);
            end
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_hold = pick_gap(recv_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Plan, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int unsigned slot;

    // Every entry is written before the first match, since an unwritten
    // entry holds no defined colour. A uniform grey palette makes every
    // entry tie, so the search must settle on entry zero.
    for (int i = 0; i < Entries; i++) plan_write(i, rgb(128, 128, 128));
    plan_match(rgb(0, 0, 0));
    plan_match(rgb(128, 128, 128));

    // The highest index and the extremes of each channel; two black entries
    // so that an exact match must give the first of them.
    plan_write(Entries - 1, rgb(255, 255, 255));
    plan_write(7, rgb(0, 0, 0));
    plan_write(9, rgb(0, 0, 0));
    plan_match(rgb(0, 0, 0));
    plan_match(rgb(255, 255, 255));
    plan_match(rgb(128, 128, 128));

    // A tie at a non-zero distance, resolved towards the lower index.
    plan_write(40, rgb(60, 128, 128));
    plan_write(41, rgb(68, 128, 128));
    plan_match(rgb(64, 128, 128));

    // Entry zero matched exactly, then at the largest possible distance from a pixel.
    plan_write(0, rgb(255, 0, 255));
    plan_match(rgb(255, 0, 255));
    plan_match(rgb(0, 255, 0));
    plan_write(128, rgb(0, 255, 0));
    plan_match(rgb(0, 255, 0));

    // Refill with random colours, top down, before the random part.
    for (int i = Entries - 1; i >= 0; i--) plan_write(i, random_colour());

    // Random part: roughly three matches to each write. Writes sometimes copy
    // an existing colour to create ties; matches are partly noise and partly
    // aimed at or just beside a colour in the palette.
    for (int n = 0; n < RandomRequests; n++) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, Entries - 1);
      if (pick < 18) plan_write(slot, random_colour());
      else if (pick < 24) plan_write(slot, planned_palette[$urandom_range(0, Entries - 1)]);
      else if (pick < 28) plan_write(slot, extreme_colour());
      else if (pick < 52) plan_match(random_colour());
      else if (pick < 60) plan_match(extreme_colour());
      else if (pick < 84) plan_match(near_colour(planned_palette[slot]));
      else plan_match(planned_palette[slot]);
    end
    requests_planned = pending_requests.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_taken < requests_planned) @(posedge clk);
    while (awaited_indices.size() != 0) @(posedge clk);
    // Allow a full pass along the row for any stray result to show itself.
    repeat (Entries + 40) @(posedge clk);

    $display("Covered %0d palette writes and %0d pixel matches; %0d indices returned,",
             writes_taken, matches_taken, results_seen);
    $display("%0d of the matches hit a palette colour exactly; %0d failures.",
             exact_hits, failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("Timed out with %0d of %0d requests taken and %0d indices owed.",
             requests_taken, requests_planned, awaited_indices.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
